@@ hw/rtl/abed_pkg.sv @@
// Shared types and constants for the accelerometer burst event detector.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package abed_pkg;

   // Register indexes on the configuration port
   localparam int unsigned CsrIdxW = 4;
   localparam logic [CsrIdxW-1:0] CSR_BASE_X    = 4'd0;
   localparam logic [CsrIdxW-1:0] CSR_BASE_Y    = 4'd1;
   localparam logic [CsrIdxW-1:0] CSR_BASE_Z    = 4'd2;
   localparam logic [CsrIdxW-1:0] CSR_TRIGGER   = 4'd3;
   localparam logic [CsrIdxW-1:0] CSR_PEAK_MIN  = 4'd4;
   localparam logic [CsrIdxW-1:0] CSR_WINDOW    = 4'd5;
   localparam logic [CsrIdxW-1:0] CSR_LOCKOUT   = 4'd6;
   localparam logic [CsrIdxW-1:0] CSR_RATIO_MIN = 4'd7;

   localparam int unsigned CsrDataW = 17;

   // Register reset values
   localparam logic [16:0] TRIGGER_RST   = 17'd4000;
   localparam logic [16:0] PEAK_MIN_RST  = 17'd6000;
   localparam logic [15:0] WINDOW_RST    = 16'd300;
   localparam logic [15:0] LOCKOUT_RST   = 16'd500;
   localparam logic [8:0]  RATIO_MIN_RST = 9'd0;

   // Damage and confirmation settings
   localparam logic [15:0] DAMAGE_BASE     = 16'd10;
   localparam logic [15:0] DAMAGE_SCALE_Q8 = 16'd256;
   localparam logic        CHECK_RATIO     = 1'b1;

   // Shared multiplier operand and product widths
   localparam int unsigned MulW  = 18;
   localparam int unsigned ProdW = 2 * MulW;

   // Square root unit: radicand and root widths, one root bit per step
   localparam int unsigned RadW  = 34;
   localparam int unsigned RootW = 17;
   localparam int unsigned RemW  = 18;

   typedef struct packed {
      logic signed [15:0] base_x;
      logic signed [15:0] base_y;
      logic signed [15:0] base_z;
      logic [16:0]        trigger;
      logic [16:0]        peak_min;
      logic [15:0]        window_len;
      logic [15:0]        lockout;
      logic [8:0]         ratio_min;
   } cfg_type;

endpackage

@@ hw/rtl/abed_csr.sv @@
// Configuration register file of the burst event detector.
// Depends on abed_pkg for register indexes, reset values and cfg_type.
`timescale 1ns / 1ps

module abed_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [abed_pkg::CsrIdxW-1:0]     csr_index,
   input  logic [abed_pkg::CsrDataW-1:0]    csr_wdata,
   output abed_pkg::cfg_type                cfg
);
   import abed_pkg::*;

   cfg_type cfg_ff;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   // Write one register per beat; drop indexes beyond the list
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.base_x     <= '0;
         cfg_ff.base_y     <= '0;
         cfg_ff.base_z     <= '0;
         cfg_ff.trigger    <= TRIGGER_RST;
         cfg_ff.peak_min   <= PEAK_MIN_RST;
         cfg_ff.window_len <= WINDOW_RST;
         cfg_ff.lockout    <= LOCKOUT_RST;
         cfg_ff.ratio_min  <= RATIO_MIN_RST;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_BASE_X:    cfg_ff.base_x     <= csr_wdata[15:0];
            CSR_BASE_Y:    cfg_ff.base_y     <= csr_wdata[15:0];
            CSR_BASE_Z:    cfg_ff.base_z     <= csr_wdata[15:0];
            CSR_TRIGGER:   cfg_ff.trigger    <= csr_wdata[16:0];
            CSR_PEAK_MIN:  cfg_ff.peak_min   <= csr_wdata[16:0];
            CSR_WINDOW:    cfg_ff.window_len <= csr_wdata[15:0];
            CSR_LOCKOUT:   cfg_ff.lockout    <= csr_wdata[15:0];
            CSR_RATIO_MIN: cfg_ff.ratio_min  <= csr_wdata[8:0];
            default: ;
         endcase
      end
   end

endmodule

@@ hw/rtl/abed_mul.sv @@
// Shared signed 18 x 18 multiplier with a registered product.
// Depends on abed_pkg for operand and product widths.
`timescale 1ns / 1ps

module abed_mul (
   input  logic                                clock,
   input  logic signed [abed_pkg::MulW-1:0]    op_a,
   input  logic signed [abed_pkg::MulW-1:0]    op_b,
   output logic signed [abed_pkg::ProdW-1:0]   product
);
   import abed_pkg::*;

   logic signed [ProdW-1:0] prod_ff;

   // Register the product; the result is ready in the cycle after issue
   always_ff @(posedge clock) begin
      prod_ff <= op_a * op_b;
   end

   assign product = prod_ff;

endmodule

@@ hw/rtl/abed_isqrt.sv @@
// Iterative integer square root, one root bit per cycle (restoring method).
// Depends on abed_pkg for radicand, root and remainder widths.
`timescale 1ns / 1ps

module abed_isqrt (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [abed_pkg::RadW-1:0]    radicand,
   output logic                         done,
   output logic [abed_pkg::RootW-1:0]   root
);
   import abed_pkg::*;

   localparam int unsigned CntW = $clog2(RootW);
   localparam logic [CntW-1:0] LastStep = CntW'(RootW - 1);

   logic [RadW-1:0]  rad_ff;
   logic [RemW-1:0]  rem_ff;
   logic [RootW-1:0] root_ff;
   logic [CntW-1:0]  cnt_ff;
   logic             busy_ff;
   logic             done_ff;

   logic [RemW+1:0]  rem_sh;
   logic [RemW+1:0]  trial;
   logic             fits;

   // Bring down the next two radicand bits and try the next root bit
   assign rem_sh = {rem_ff, rad_ff[RadW-1 -: 2]};
   assign trial  = {1'b0, root_ff, 2'b01};
   assign fits   = rem_sh >= trial;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start && !busy_ff) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == LastStep) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   // Datapath: load on start, advance one digit pair per busy cycle
   always_ff @(posedge clock) begin
      if (start && !busy_ff) begin
         rad_ff  <= radicand;
         rem_ff  <= '0;
         root_ff <= '0;
      end else if (busy_ff) begin
         rad_ff <= {rad_ff[RadW-3:0], 2'b00};
         if (fits) begin
            rem_ff  <= RemW'(rem_sh - trial);
            root_ff <= {root_ff[RootW-2:0], 1'b1};
         end else begin
            rem_ff  <= rem_sh[RemW-1:0];
            root_ff <= {root_ff[RootW-2:0], 1'b0};
         end
      end
   end

   assign done = done_ff;
   assign root = root_ff;

endmodule

@@ hw/rtl/accel_burst_event_detector.sv @@
// Accelerometer burst event detector: baseline removal, magnitude and window machine.
// A sample passes the squares on the shared multiplier, 17 square root steps plus a
// hand-over of the root, and the decision states ST_RATIO, ST_DMG and ST_FIN (which
// waits for a free result register) before rsp_valid rises.
// One sample at a time: no new sample is taken until the last one leaves ST_FIN.
// req_ready is high only between samples; a finished result waits in the rsp register.
// Reset is synchronous, active high: registers to their defaults, window machine idle.
`timescale 1ns / 1ps

module accel_burst_event_detector #(
   parameter logic [15:0] DamageBase    = abed_pkg::DAMAGE_BASE,
   parameter logic [15:0] DamageScaleQ8 = abed_pkg::DAMAGE_SCALE_Q8,
   parameter logic        CheckRatio    = abed_pkg::CHECK_RATIO
) (
   input  logic                               clock,
   input  logic                               reset,
   // sample channel
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic signed [15:0]                 req_sample_x,
   input  logic signed [15:0]                 req_sample_y,
   input  logic signed [15:0]                 req_sample_z,
   input  logic [31:0]                        req_time_ms,
   // result channel
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic                               rsp_event_valid,
   output logic [16:0]                        rsp_magnitude_now,
   output logic [16:0]                        rsp_event_peak,
   output logic [15:0]                        rsp_above_count,
   output logic [15:0]                        rsp_window_count,
   output logic [15:0]                        rsp_strength,
   // configuration channel
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [abed_pkg::CsrIdxW-1:0]       csr_index,
   input  logic [abed_pkg::CsrDataW-1:0]      csr_wdata
);
   import abed_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE, ST_SQR, ST_ROOT, ST_RATIO, ST_DMG, ST_FIN
   } seq_type;

   typedef enum logic [1:0] {
      PH_IDLE   = 2'd0,
      PH_ACTIVE = 2'd1,
      PH_COOL   = 2'd2
   } phase_type;

   cfg_type cfg;

   // Sequencer and window state
   seq_type             state_ff;
   logic [1:0]          step_ff;
   phase_type           phase_ff;
   logic [31:0]         window_start_ff;
   logic [31:0]         lockout_start_ff;
   logic [16:0]         peak_ff;
   logic [15:0]         seen_ff;
   logic [15:0]         above_ff;

   // Per-sample working registers
   logic signed [16:0]  dx_ff, dy_ff, dz_ff;
   logic [31:0]         now_ff;
   logic [RadW-1:0]     acc_ff;
   logic [16:0]         mag_ff;
   logic [24:0]         ratio_prod_ff;

   // Result register
   logic                rsp_valid_ff;
   logic                rsp_event_ff;
   logic [16:0]         rsp_mag_ff;
   logic [16:0]         rsp_peak_ff;
   logic [15:0]         rsp_above_ff;
   logic [15:0]         rsp_count_ff;
   logic [15:0]         rsp_str_ff;

   logic signed [MulW-1:0]  mul_a, mul_b;
   logic signed [ProdW-1:0] prod;
   logic [RadW-1:0]         acc_in;
   logic                    root_start;
   logic                    root_done;
   logic [RootW-1:0]        root;

   logic [15:0]   seen_in;
   logic [15:0]   above_in;
   logic [16:0]   peak_in;
   logic [16:0]   excess;
   logic [31:0]   win_elapsed;
   logic [31:0]   lock_elapsed;
   logic          expired;
   logic          ended;
   logic [18:0]   trig_x3;
   logic          ratio_fail;
   logic          confirm;
   logic [25:0]   dmg_sum;
   logic [15:0]   strength_in;
   logic          out_free;

   abed_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   abed_mul u_mul (
      .clock   (clock),
      .op_a    (mul_a),
      .op_b    (mul_b),
      .product (prod)
   );

   abed_isqrt u_isqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (root_start),
      .radicand (acc_in),
      .done     (root_done),
      .root     (root)
   );

   assign req_ready = (state_ff == ST_IDLE);
   assign out_free  = !rsp_valid_ff || rsp_ready;

   // Window bookkeeping as if this sample lands in an active window
   assign seen_in  = (seen_ff == 16'hFFFF) ? seen_ff : seen_ff + 16'd1;
   assign above_in = (mag_ff > cfg.trigger && above_ff != 16'hFFFF)
                     ? above_ff + 16'd1 : above_ff;
   assign peak_in  = (mag_ff > peak_ff) ? mag_ff : peak_ff;
   assign excess   = (peak_in > cfg.trigger) ? peak_in - cfg.trigger : 17'd0;

   assign win_elapsed  = now_ff - window_start_ff;
   assign lock_elapsed = now_ff - lockout_start_ff;
   assign expired      = win_elapsed >= {16'd0, cfg.window_len};
   assign trig_x3      = {1'b0, cfg.trigger, 1'b0} + {2'b00, cfg.trigger};
   assign ended        = {mag_ff, 2'b00} < trig_x3;

   assign ratio_fail = CheckRatio && ({1'b0, above_in, 8'd0} < ratio_prod_ff);
   assign confirm    = (peak_in >= cfg.peak_min) && !ratio_fail;
   assign dmg_sum    = {10'd0, DamageBase} + 26'(prod[33:8]);
   assign strength_in = (dmg_sum > 26'd65535) ? 16'hFFFF : dmg_sum[15:0];

   // Select shared multiplier operands per sequencer step
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         ST_SQR: begin
            case (step_ff)
               2'd0: begin
                  mul_a = MulW'(dx_ff);
                  mul_b = MulW'(dx_ff);
               end
               2'd1: begin
                  mul_a = MulW'(dy_ff);
                  mul_b = MulW'(dy_ff);
               end
               2'd2: begin
                  mul_a = MulW'(dz_ff);
                  mul_b = MulW'(dz_ff);
               end
               default: ;
            endcase
         end
         ST_RATIO: begin
            mul_a = {9'd0, cfg.ratio_min};
            mul_b = {2'd0, seen_in};
         end
         ST_DMG, ST_FIN: begin
            mul_a = {2'd0, DamageScaleQ8};
            mul_b = {1'b0, excess};
         end
         default: ;
      endcase
   end

   // Accumulate the squares; the last one goes straight to the root unit
   assign acc_in     = (step_ff == 2'd1) ? prod[RadW-1:0] : acc_ff + prod[RadW-1:0];
   assign root_start = (state_ff == ST_SQR) && (step_ff == 2'd3);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= ST_IDLE;
         step_ff          <= '0;
         phase_ff         <= PH_IDLE;
         window_start_ff  <= '0;
         lockout_start_ff <= '0;
         peak_ff          <= '0;
         seen_ff          <= '0;
         above_ff         <= '0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         // drop the result once taken; a result leaving ST_FIN takes its place instead
         if (rsp_valid_ff && rsp_ready && state_ff != ST_FIN) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (req_valid) begin
                  dx_ff    <= 17'(req_sample_x) - 17'(cfg.base_x);
                  dy_ff    <= 17'(req_sample_y) - 17'(cfg.base_y);
                  dz_ff    <= 17'(req_sample_z) - 17'(cfg.base_z);
                  now_ff   <= req_time_ms;
                  step_ff  <= '0;
                  state_ff <= ST_SQR;
               end
            end
            ST_SQR: begin
               step_ff <= step_ff + 2'd1;
               if (step_ff != 2'd0) begin
                  acc_ff <= acc_in;
               end
               if (step_ff == 2'd3) begin
                  state_ff <= ST_ROOT;
               end
            end
            ST_ROOT: begin
               if (root_done) begin
                  mag_ff   <= root;
                  state_ff <= ST_RATIO;
               end
            end
            ST_RATIO: begin
               state_ff <= ST_DMG;
            end
            ST_DMG: begin
               ratio_prod_ff <= prod[24:0];
               state_ff      <= ST_FIN;
            end
            ST_FIN: begin
               // commit the window machine and load the result beat
               if (out_free) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_mag_ff   <= mag_ff;
                  rsp_event_ff <= 1'b0;
                  rsp_peak_ff  <= '0;
                  rsp_above_ff <= '0;
                  rsp_count_ff <= '0;
                  rsp_str_ff   <= '0;
                  unique case (phase_ff)
                     PH_IDLE: begin
                        if (mag_ff > cfg.trigger) begin
                           phase_ff        <= PH_ACTIVE;
                           window_start_ff <= now_ff;
                           peak_ff         <= mag_ff;
                           seen_ff         <= 16'd1;
                           above_ff        <= 16'd1;
                        end
                     end
                     PH_ACTIVE: begin
                        seen_ff  <= seen_in;
                        above_ff <= above_in;
                        peak_ff  <= peak_in;
                        if (expired || ended) begin
                           phase_ff         <= PH_COOL;
                           lockout_start_ff <= now_ff;
                           if (confirm) begin
                              rsp_event_ff <= 1'b1;
                              rsp_peak_ff  <= peak_in;
                              rsp_above_ff <= above_in;
                              rsp_count_ff <= seen_in;
                              rsp_str_ff   <= strength_in;
                           end
                        end
                     end
                     PH_COOL: begin
                        if (lock_elapsed >= {16'd0, cfg.lockout}) begin
                           phase_ff <= PH_IDLE;
                        end
                     end
                     default: begin
                        phase_ff <= PH_IDLE;
                     end
                  endcase
                  state_ff <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_event_valid   = rsp_event_ff;
   assign rsp_magnitude_now = rsp_mag_ff;
   assign rsp_event_peak    = rsp_peak_ff;
   assign rsp_above_count   = rsp_above_ff;
   assign rsp_window_count  = rsp_count_ff;
   assign rsp_strength      = rsp_str_ff;

   // One sample at a time: no new beat right after one is taken
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("req_ready high right after an accepted sample");

   // A non-event result carries zero event fields
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_event_valid) |->
         (rsp_event_peak == 17'd0 && rsp_above_count == 16'd0 &&
          rsp_window_count == 16'd0 && rsp_strength == 16'd0))
      else $error("event fields set on a result without an event");

   // Above-threshold count never exceeds the window count
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_event_valid) |-> (rsp_above_count <= rsp_window_count))
      else $error("above count exceeds window count");

   // The root unit finishes only while the sequencer waits for it
   assert property (@(posedge clock) disable iff (reset)
      root_done |-> (state_ff == ST_ROOT))
      else $error("square root finished outside its step");

endmodule
